@@ rtl/core/buc_pkg.sv @@
package buc_pkg;

  // Default store depths, handed down through the top-level parameters.
  localparam int unsigned EtaBinsDefault        = 128;
  localparam int unsigned MomentumPointsDefault = 128;

  // Fixed field widths.
  localparam int unsigned EdgeW = 16;
  localparam int unsigned MomW  = 24;
  localparam int unsigned FracW = 16;
  localparam int unsigned IdxW  = 7;
  localparam int unsigned CntW  = 8;

  // Scale factors in Q2.16: unity, twice unity for the no-match down scale, and zero.
  localparam logic [17:0] FactorOne = 18'h10000;
  localparam logic [17:0] FactorTwo = 18'h20000;
  localparam logic [17:0] FactorNil = 18'h00000;
  localparam logic [MomW-1:0] MomMax = 24'hFFFFFF;

  // Register byte addresses on the configuration port.
  localparam logic [3:0] AddrDirection = 4'h0;
  localparam logic [3:0] AddrBinCount  = 4'h4;
  localparam logic [3:0] AddrThrCount  = 4'h8;

  // Item kinds carried in tuser.
  typedef enum logic [1:0] {
    CMD_LOAD_EDGES     = 2'd0,
    CMD_LOAD_THRESHOLD = 2'd1,
    CMD_LOAD_FRACTION  = 2'd2,
    CMD_QUERY          = 2'd3
  } buc_cmd_e;

  // Write and read strobes from the sequencer to the tables.
  typedef struct packed {
    logic edge_we;
    logic thr_we;
    logic frac_we;
    logic edge_re;
    logic pt_re;
  } buc_tbl_ctrl_t;

endpackage

@@ rtl/core/buc_tables.sv @@
module buc_tables import buc_pkg::*; #(
  parameter int unsigned ETA_BINS        = EtaBinsDefault,
  parameter int unsigned MOMENTUM_POINTS = MomentumPointsDefault,
  localparam int unsigned BinAw  = (ETA_BINS > 1) ? $clog2(ETA_BINS) : 1,
  localparam int unsigned PtAw   = (MOMENTUM_POINTS > 1) ? $clog2(MOMENTUM_POINTS) : 1,
  localparam int unsigned FracAw = (ETA_BINS * MOMENTUM_POINTS > 1) ?
                                   $clog2(ETA_BINS * MOMENTUM_POINTS) : 1
) (
  input  logic                clk_i,
  input  buc_tbl_ctrl_t       ctrl_i,
  input  logic [BinAw-1:0]    edge_wr_addr_i,
  input  logic [EdgeW-1:0]    edge_low_i,
  input  logic [EdgeW-1:0]    edge_high_i,
  input  logic [PtAw-1:0]     thr_wr_addr_i,
  input  logic [MomW-1:0]     thr_value_i,
  input  logic [FracAw-1:0]   frac_wr_addr_i,
  input  logic [FracW-1:0]    frac_value_i,
  input  logic [BinAw-1:0]    bin_rd_addr_i,
  input  logic [PtAw-1:0]     pt_rd_addr_i,
  input  logic [FracAw-1:0]   frac_rd_addr_i,
  output logic [EdgeW-1:0]    edge_low_o,
  output logic [EdgeW-1:0]    edge_high_o,
  output logic [MomW-1:0]     thr_o,
  output logic [FracW-1:0]    frac_o
);

  logic [EdgeW-1:0] low_mem  [ETA_BINS];
  logic [EdgeW-1:0] high_mem [ETA_BINS];
  logic [MomW-1:0]  thr_mem  [MOMENTUM_POINTS];
  logic [FracW-1:0] frac_mem [ETA_BINS * MOMENTUM_POINTS];

  // Bin edge store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.edge_we) begin
      low_mem[edge_wr_addr_i]  <= edge_low_i;
      high_mem[edge_wr_addr_i] <= edge_high_i;
    end
    if (ctrl_i.edge_re) begin
      edge_low_o  <= low_mem[bin_rd_addr_i];
      edge_high_o <= high_mem[bin_rd_addr_i];
    end
  end

  // Threshold store.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.thr_we) begin
      thr_mem[thr_wr_addr_i] <= thr_value_i;
    end
    if (ctrl_i.pt_re) begin
      thr_o <= thr_mem[pt_rd_addr_i];
    end
  end

  // Fraction store, addressed bin * MOMENTUM_POINTS + point.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.frac_we) begin
      frac_mem[frac_wr_addr_i] <= frac_value_i;
    end
    if (ctrl_i.pt_re) begin
      frac_o <= frac_mem[frac_rd_addr_i];
    end
  end

endmodule

@@ rtl/core/buc_scale.sv @@
module buc_scale import buc_pkg::*; (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic             found_i,
  input  logic             up_i,
  input  logic [FracW-1:0] fraction_i,
  input  logic [MomW-1:0]  momentum_i,
  output logic [MomW-1:0]  scaled_o
);

  logic [17:0] factor;
  logic [41:0] product_q;
  logic [25:0] shifted;

  // With no match the fraction counts as minus one: factor two down, zero up.
  always_comb begin
    if (!found_i) begin
      factor = up_i ? FactorNil : FactorTwo;
    end else if (up_i) begin
      factor = FactorOne + 18'(fraction_i);
    end else begin
      factor = FactorOne - 18'(fraction_i);
    end
  end

  // The product is registered before the saturation stage.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      product_q <= 42'(momentum_i) * 42'(factor);
    end
  end

  // Drop the sixteen fraction bits and saturate to the momentum range.
  assign shifted  = product_q[41:16];
  assign scaled_o = (|shifted[25:24]) ? MomMax : shifted[MomW-1:0];

endmodule

@@ rtl/core/binned_uncertainty_scaler.sv @@
// Loads go straight into the tables. A query scans the bins up to the clamped bin count and,
// in each bin that holds the eta, the thresholds up to the clamped threshold count; each
// table entry is read in a read state and compared in a compare state. The next item is taken
// in the cycle after the result is loaded, and an unclaimed earlier result holds that load back.
// Reset (rst_ni low, asynchronous) clears the configuration registers, the sequencer state
// and output valid; the table memories are not cleared and hold nothing defined until loaded.
module binned_uncertainty_scaler import buc_pkg::*; #(
  parameter int unsigned ETA_BINS        = EtaBinsDefault,
  parameter int unsigned MOMENTUM_POINTS = MomentumPointsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata from bit 0: bin_index[6:0], point_index[13:7], edge_low[29:14],
  // edge_high[45:30], threshold_value[69:46], fraction_value[85:70],
  // query_momentum[109:86], query_eta[125:110], zero fill[127:126].
  input  logic [127:0] s_axis_tdata_i,
  // tuser: command[1:0].
  input  logic [1:0]   s_axis_tuser_i,
  // Output stream.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata from bit 0: scaled_momentum[23:0], fraction_used[39:24].
  output logic [39:0]  m_axis_tdata_o,
  // tuser: lookup_error[0].
  output logic         m_axis_tuser_o,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned BinAw  = (ETA_BINS > 1) ? $clog2(ETA_BINS) : 1;
  localparam int unsigned PtAw   = (MOMENTUM_POINTS > 1) ? $clog2(MOMENTUM_POINTS) : 1;
  localparam int unsigned FracAw = (ETA_BINS * MOMENTUM_POINTS > 1) ?
                                   $clog2(ETA_BINS * MOMENTUM_POINTS) : 1;
  localparam int unsigned BinCw  = $clog2(ETA_BINS + 1);
  localparam int unsigned PtCw   = $clog2(MOMENTUM_POINTS + 1);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StBinRd  = 3'd1;
  localparam logic [2:0] StBinCmp = 3'd2;
  localparam logic [2:0] StPtRd   = 3'd3;
  localparam logic [2:0] StPtCmp  = 3'd4;
  localparam logic [2:0] StMul    = 3'd5;
  localparam logic [2:0] StDone   = 3'd6;

  // Input fields.
  buc_cmd_e                cmd;
  logic [IdxW-1:0]         in_bin;
  logic [IdxW-1:0]         in_pt;
  logic [EdgeW-1:0]        in_edge_low;
  logic [EdgeW-1:0]        in_edge_high;
  logic [MomW-1:0]         in_thr;
  logic [FracW-1:0]        in_frac;
  logic [MomW-1:0]         in_mom;
  logic [EdgeW-1:0]        in_eta;

  assign cmd          = buc_cmd_e'(s_axis_tuser_i);
  assign in_bin       = s_axis_tdata_i[6:0];
  assign in_pt        = s_axis_tdata_i[13:7];
  assign in_edge_low  = s_axis_tdata_i[29:14];
  assign in_edge_high = s_axis_tdata_i[45:30];
  assign in_thr       = s_axis_tdata_i[69:46];
  assign in_frac      = s_axis_tdata_i[85:70];
  assign in_mom       = s_axis_tdata_i[109:86];
  assign in_eta       = s_axis_tdata_i[125:110];

  // Configuration registers.
  logic            direction_up_q;
  logic [CntW-1:0] bin_count_q;
  logic [CntW-1:0] thr_count_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_up_q <= 1'b0;
      bin_count_q    <= '0;
      thr_count_q    <= '0;
    end else if (cfg_wr) begin
      unique case (paddr)
        AddrDirection: direction_up_q <= pwdata[0];
        AddrBinCount:  bin_count_q    <= pwdata[CntW-1:0];
        AddrThrCount:  thr_count_q    <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      AddrDirection: prdata = {31'd0, direction_up_q};
      AddrBinCount:  prdata = 32'(bin_count_q);
      AddrThrCount:  prdata = 32'(thr_count_q);
      default:       prdata = '0;
    endcase
  end

  // Sequencer state and query context.
  logic [2:0]              state_q, state_d;
  logic [BinCw-1:0]        nb_q, nb_d, b_q, b_d;
  logic [PtCw-1:0]         np_q, np_d, p_q, p_d;
  logic [FracAw-1:0]       base_q, base_d;
  logic [MomW-1:0]         mom_q, mom_d;
  logic [EdgeW-1:0]        eta_q, eta_d;
  logic                    found_q, found_d;
  logic [FracW-1:0]        frac_q, frac_d;
  logic                    out_valid_q, out_valid_d;
  logic [MomW-1:0]         out_mom_q;
  logic [FracW-1:0]        out_frac_q;
  logic                    out_err_q;
  logic                    out_load;

  logic                    in_fire;
  logic                    bin_ok, pt_ok;
  logic                    bin_match;
  buc_tbl_ctrl_t           tbl_ctrl;
  logic [EdgeW-1:0]        rd_low, rd_high;
  logic [MomW-1:0]         rd_thr;
  logic [FracW-1:0]        rd_frac;
  logic [MomW-1:0]         scaled;
  logic                    mul_load;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign bin_ok          = 32'(in_bin) < ETA_BINS;
  assign pt_ok           = 32'(in_pt) < MOMENTUM_POINTS;
  assign bin_match       = ($signed(eta_q) >= $signed(rd_low)) &&
                           ($signed(eta_q) < $signed(rd_high));
  assign mul_load        = (state_q == StMul);

  // Table strobes: loads write straight from the accepted item.
  always_comb begin
    tbl_ctrl.edge_we = in_fire && (cmd == CMD_LOAD_EDGES) && bin_ok;
    tbl_ctrl.thr_we  = in_fire && (cmd == CMD_LOAD_THRESHOLD) && pt_ok;
    tbl_ctrl.frac_we = in_fire && (cmd == CMD_LOAD_FRACTION) && bin_ok && pt_ok;
    tbl_ctrl.edge_re = (state_q == StBinRd) && (b_q < nb_q);
    tbl_ctrl.pt_re   = (state_q == StPtRd) && (p_q < np_q);
  end

  buc_tables #(
    .ETA_BINS        (ETA_BINS),
    .MOMENTUM_POINTS (MOMENTUM_POINTS)
  ) u_tables (
    .clk_i          (clk_i),
    .ctrl_i         (tbl_ctrl),
    .edge_wr_addr_i (BinAw'(in_bin)),
    .edge_low_i     (in_edge_low),
    .edge_high_i    (in_edge_high),
    .thr_wr_addr_i  (PtAw'(in_pt)),
    .thr_value_i    (in_thr),
    .frac_wr_addr_i (FracAw'(32'(in_bin) * MOMENTUM_POINTS + 32'(in_pt))),
    .frac_value_i   (in_frac),
    .bin_rd_addr_i  (b_q[BinAw-1:0]),
    .pt_rd_addr_i   (p_q[PtAw-1:0]),
    .frac_rd_addr_i (base_q + FracAw'(p_q)),
    .edge_low_o     (rd_low),
    .edge_high_o    (rd_high),
    .thr_o          (rd_thr),
    .frac_o         (rd_frac)
  );

  buc_scale u_scale (
    .clk_i      (clk_i),
    .load_i     (mul_load),
    .found_i    (found_q),
    .up_i       (direction_up_q),
    .fraction_i (frac_q),
    .momentum_i (mom_q),
    .scaled_o   (scaled)
  );

  // Scan sequencer: bins in order, and the thresholds of every bin that holds the eta.
  always_comb begin
    state_d     = state_q;
    nb_d        = nb_q;
    np_d        = np_q;
    b_d         = b_q;
    p_d         = p_q;
    base_d      = base_q;
    mom_d       = mom_q;
    eta_d       = eta_q;
    found_d     = found_q;
    frac_d      = frac_q;
    out_load    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_fire && (cmd == CMD_QUERY)) begin
          nb_d    = (32'(bin_count_q) > ETA_BINS) ? BinCw'(ETA_BINS) : BinCw'(bin_count_q);
          np_d    = (32'(thr_count_q) > MOMENTUM_POINTS) ?
                    PtCw'(MOMENTUM_POINTS) : PtCw'(thr_count_q);
          b_d     = '0;
          base_d  = '0;
          mom_d   = in_mom;
          eta_d   = in_eta;
          found_d = 1'b0;
          frac_d  = '0;
          state_d = StBinRd;
        end
      end
      StBinRd: begin
        state_d = (b_q < nb_q) ? StBinCmp : StMul;
      end
      StBinCmp: begin
        if (bin_match) begin
          p_d     = '0;
          state_d = StPtRd;
        end else begin
          b_d     = b_q + BinCw'(1);
          base_d  = base_q + FracAw'(MOMENTUM_POINTS);
          state_d = StBinRd;
        end
      end
      StPtRd: begin
        if (p_q < np_q) begin
          state_d = StPtCmp;
        end else begin
          b_d     = b_q + BinCw'(1);
          base_d  = base_q + FracAw'(MOMENTUM_POINTS);
          state_d = StBinRd;
        end
      end
      StPtCmp: begin
        // Every threshold reached replaces the fraction, so the last match wins.
        if (mom_q >= rd_thr) begin
          found_d = 1'b1;
          frac_d  = rd_frac;
        end
        p_d     = p_q + PtCw'(1);
        state_d = StPtRd;
      end
      StMul: begin
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nb_q    <= nb_d;
    np_q    <= np_d;
    b_q     <= b_d;
    p_q     <= p_d;
    base_q  <= base_d;
    mom_q   <= mom_d;
    eta_q   <= eta_d;
    found_q <= found_d;
    frac_q  <= frac_d;
  end

  // Output register: holds a result until it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // A zero fraction flags both no match and a matched zero.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mom_q  <= scaled;
      out_frac_q <= frac_q;
      out_err_q  <= (frac_q == '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_frac_q, out_mom_q};
  assign m_axis_tuser_o  = out_err_q;

endmodule
